@@ sv/fixed_block_pool_allocator_top_assert.svh @@
// Assertion macros for the fixed block pool allocator.
// Included by the top level; no other dependencies. Empty under synthesis.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define FBPA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FBPA_ASSERT_HOLDS(label, clk, rst, cond, msg)
`define FBPA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/fbpa_pkg.sv @@
// Shared constants and types for the fixed block pool allocator.
// No dependencies; used by the top level.
package fbpa_pkg;

   localparam int MAX_BLOCKS_DEF = 256;
   localparam int ADDR_WIDTH_DEF = 32;

   localparam int FIELD_ADDR_W = 32;
   localparam int SIZE_W       = 17;
   localparam int COUNT_W      = 9;
   localparam int FUNC_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int USED_W       = 25;
   localparam int CSR_INDEX_W  = 2;
   localparam int DIV_STEPS    = 32;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam func_type FUNC_ALLOC = 2'd0;
   localparam func_type FUNC_FREE  = 2'd1;
   localparam func_type FUNC_RESET = 2'd2;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_TOO_LARGE = 3'd1;
   localparam status_type ST_EMPTY     = 3'd2;
   localparam status_type ST_BAD_ADDR  = 3'd3;
   localparam status_type ST_NONE_OUT  = 3'd4;
   localparam status_type ST_NULL      = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] REG_BASE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT = 2'd2;

   localparam logic [FIELD_ADDR_W-1:0] BASE_RESET  = 32'd65536;
   localparam logic [SIZE_W-1:0]       SIZE_RESET  = 17'd64;
   localparam logic [COUNT_W-1:0]      COUNT_RESET = 9'd256;

   localparam logic [SIZE_W-1:0] MIN_BSIZE = 17'd8;
   localparam logic [SIZE_W-1:0] MAX_BSIZE = 17'd65536;

endpackage

@@ sv/fbpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the free list's next-index table.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fixed_block_pool_allocator_top.sv @@
// Top level of the fixed block pool allocator: LIFO free list, counters, divider.
// Depends on fbpa_pkg, fbpa_ram and fixed_block_pool_allocator_top_assert.svh.
//
//   Channel  Direction  Handshake           Beat contents
//   req_     in         req_valid/req_stall func, request size, address to free
//   rsp_     out        rsp_valid/rsp_stall block address, status, pool totals
//   csr_     in         csr_wr_en           register index and write data
//
// An allocate passes DECODE, ALLOC and RESP; a free passes DECODE, DIV, FREE and RESP:
// a restoring divider shares one 19-bit subtractor over 32 steps, one quotient bit
// per cycle. A pool reset, an unknown operation or an item refused at decode goes
// from DECODE to RESP; after a pool reset the next-index table is rebuilt one entry a
// cycle, one per configured block. Reset and every register write start that rebuild.
// req_stall stays high while an item is in work; a stalled result holds the last step.
`include "fixed_block_pool_allocator_top_assert.svh"

module fixed_block_pool_allocator_top #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fbpa_pkg::FUNC_W-1:0]         req_func,
   input  logic [fbpa_pkg::FIELD_ADDR_W-1:0]   req_request_size,
   input  logic [fbpa_pkg::FIELD_ADDR_W-1:0]   req_free_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fbpa_pkg::FIELD_ADDR_W-1:0]   rsp_block_address,
   output logic [fbpa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fbpa_pkg::COUNT_W-1:0]        rsp_free_blocks,
   output logic [fbpa_pkg::USED_W-1:0]         rsp_used_bytes,
   output logic [fbpa_pkg::COUNT_W-1:0]        rsp_allocation_count,
   input  logic                                csr_wr_en,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0]    csr_wr_index,
   input  logic [fbpa_pkg::FIELD_ADDR_W-1:0]   csr_wr_data
);

   localparam int AW   = $clog2(MAX_BLOCKS);
   localparam int IW   = $clog2(MAX_BLOCKS + 1);
   localparam int PW   = IW + fbpa_pkg::SIZE_W;
   localparam int SUMW = ((PW > fbpa_pkg::FIELD_ADDR_W) ? PW : fbpa_pkg::FIELD_ADDR_W) + 1;
   localparam int AFW  = fbpa_pkg::FIELD_ADDR_W;
   localparam int SW   = fbpa_pkg::SIZE_W;
   localparam int CW   = fbpa_pkg::COUNT_W;
   localparam int UW   = fbpa_pkg::USED_W;
   localparam int DCW  = fbpa_pkg::DIV_CNT_W;

   localparam logic [IW-1:0] END_MARK = IW'(MAX_BLOCKS);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_ALLOC  = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_FREE   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   // Control state
   logic [2:0]     state_ff, state_in;
   logic [AFW-1:0] base_ff, base_in;
   logic [SW-1:0]  size_ff, size_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [UW-1:0]  used_ff, used_in;
   logic [CW-1:0]  live_ff, live_in;
   logic [IW-1:0]  clr_ptr_ff, clr_ptr_in;
   logic           clear_pending_ff, clear_pending_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [fbpa_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [AFW-1:0]              req_size_ff, req_size_in;
   logic [AFW-1:0]              free_addr_ff, free_addr_in;
   logic [AFW-1:0]              quo_ff, quo_in;
   logic [SW-1:0]               rem_ff, rem_in;
   logic [PW-1:0]               prod_ff, prod_in;
   logic [AFW-1:0]              stage_addr_ff, stage_addr_in;
   fbpa_pkg::status_type        stage_status_ff, stage_status_in;
   logic [AFW-1:0]              rsp_addr_ff, rsp_addr_in;
   fbpa_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [CW-1:0]               rsp_free_ff, rsp_free_in;
   logic [UW-1:0]               rsp_used_ff, rsp_used_in;
   logic [CW-1:0]               rsp_live_ff, rsp_live_in;

   logic [SW-1:0]   size_eff;
   logic [CW-1:0]   cnt_eff;
   logic            cfg_hit;
   logic            clr_last;
   logic            rsp_load;
   logic [AFW:0]    off_diff;
   logic [SW:0]     div_trial;
   logic [SW+1:0]   div_diff;
   logic [SUMW-1:0] alloc_sum;
   logic [AFW-1:0]  alloc_addr;
   logic [CW-1:0]   free_now;

   logic            ram_we;
   logic [AW-1:0]   ram_wa;
   logic [IW-1:0]   ram_wd;
   logic [IW-1:0]   ram_rd;

   fbpa_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_BLOCKS)
   ) u_next_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (ram_rd)
   );

   // Register values are clamped to the supported geometry.
   always_comb begin
      if (size_ff < fbpa_pkg::MIN_BSIZE) begin
         size_eff = fbpa_pkg::MIN_BSIZE;
      end else if (size_ff > fbpa_pkg::MAX_BSIZE) begin
         size_eff = fbpa_pkg::MAX_BSIZE;
      end else begin
         size_eff = size_ff;
      end
      if (count_ff == '0) begin
         cnt_eff = CW'(1);
      end else if (32'(count_ff) > 32'(MAX_BLOCKS)) begin
         cnt_eff = CW'(MAX_BLOCKS);
      end else begin
         cnt_eff = count_ff;
      end
   end

   assign cfg_hit = csr_wr_en && (csr_wr_index == fbpa_pkg::REG_BASE ||
                                  csr_wr_index == fbpa_pkg::REG_SIZE ||
                                  csr_wr_index == fbpa_pkg::REG_COUNT);
   assign clr_last  = (32'(clr_ptr_ff) + 32'd1) >= 32'(cnt_eff);
   assign off_diff  = {1'b0, free_addr_ff} - {1'b0, base_ff};
   assign div_trial = {rem_ff, quo_ff[AFW-1]};
   assign div_diff  = {1'b0, div_trial} - {2'b00, size_eff};
   assign alloc_sum = SUMW'(base_ff) + SUMW'(prod_ff);
   assign free_now  = (live_ff >= cnt_eff) ? '0 : cnt_eff - live_ff;
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != S_IDLE);

   // The allocated address wraps at the configured address width.
   always_comb begin
      for (int b = 0; b < AFW; b++) begin
         alloc_addr[b] = (b < ADDR_WIDTH) ? alloc_sum[b] : 1'b0;
      end
   end

   always_comb begin
      state_in         = state_ff;
      base_in          = base_ff;
      size_in          = size_ff;
      count_in         = count_ff;
      head_in          = head_ff;
      used_in          = used_ff;
      live_in          = live_ff;
      clr_ptr_in       = clr_ptr_ff;
      clear_pending_in = clear_pending_ff;
      div_cnt_in       = div_cnt_ff;
      func_in          = func_ff;
      req_size_in      = req_size_ff;
      free_addr_in     = free_addr_ff;
      quo_in           = quo_ff;
      rem_in           = rem_ff;
      prod_in          = PW'(head_ff) * PW'(size_eff);
      stage_addr_in    = stage_addr_ff;
      stage_status_in  = stage_status_ff;
      ram_we           = 1'b0;
      ram_wa           = clr_ptr_ff[AW-1:0];
      ram_wd           = END_MARK;

      case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            ram_wa     = clr_ptr_ff[AW-1:0];
            ram_wd     = clr_last ? END_MARK : clr_ptr_ff + IW'(1);
            clr_ptr_in = clr_ptr_ff + IW'(1);
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               req_size_in  = req_request_size;
               free_addr_in = req_free_address;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            stage_addr_in   = '0;
            stage_status_in = fbpa_pkg::ST_OK;
            state_in        = S_RESP;
            case (func_ff)
               fbpa_pkg::FUNC_ALLOC: begin
                  if (req_size_ff > AFW'(size_eff)) begin
                     stage_status_in = fbpa_pkg::ST_TOO_LARGE;
                  end else if (head_ff == END_MARK || live_ff >= cnt_eff) begin
                     stage_status_in = fbpa_pkg::ST_EMPTY;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
               fbpa_pkg::FUNC_FREE: begin
                  if (free_addr_ff == '0) begin
                     stage_status_in = fbpa_pkg::ST_NULL;
                  end else if (off_diff[AFW]) begin
                     stage_status_in = fbpa_pkg::ST_BAD_ADDR;
                  end else begin
                     quo_in     = off_diff[AFW-1:0];
                     rem_in     = '0;
                     div_cnt_in = DCW'(fbpa_pkg::DIV_STEPS - 1);
                     state_in   = S_DIV;
                  end
               end
               fbpa_pkg::FUNC_RESET: begin
                  head_in          = '0;
                  used_in          = '0;
                  live_in          = '0;
                  clear_pending_in = 1'b1;
               end
               default: begin
                  stage_status_in = fbpa_pkg::ST_OK;
               end
            endcase
         end
         S_ALLOC: begin
            // The table read was issued at the head in the previous cycle.
            head_in         = ram_rd;
            used_in         = used_ff + UW'(size_eff);
            live_in         = live_ff + CW'(1);
            stage_addr_in   = alloc_addr;
            stage_status_in = fbpa_pkg::ST_OK;
            state_in        = S_RESP;
         end
         S_DIV: begin
            if (!div_diff[SW+1]) begin
               rem_in = div_diff[SW-1:0];
               quo_in = {quo_ff[AFW-2:0], 1'b1};
            end else begin
               rem_in = div_trial[SW-1:0];
               quo_in = {quo_ff[AFW-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - DCW'(1);
            if (div_cnt_ff == '0) begin
               state_in = S_FREE;
            end
         end
         S_FREE: begin
            // A quotient at or past the count means the address lies beyond the pool.
            stage_addr_in = '0;
            state_in      = S_RESP;
            if (rem_ff != '0 || quo_ff >= AFW'(cnt_eff)) begin
               stage_status_in = fbpa_pkg::ST_BAD_ADDR;
            end else if (live_ff == '0 || used_ff < UW'(size_eff)) begin
               stage_status_in = fbpa_pkg::ST_NONE_OUT;
            end else begin
               ram_we          = 1'b1;
               ram_wa          = quo_ff[AW-1:0];
               ram_wd          = head_ff;
               head_in         = quo_ff[IW-1:0];
               used_in         = used_ff - UW'(size_eff);
               live_in         = live_ff - CW'(1);
               stage_status_in = fbpa_pkg::ST_OK;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               clr_ptr_in       = '0;
               clear_pending_in = 1'b0;
               state_in         = clear_pending_ff ? S_CLEAR : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Any register write rebuilds the pool for the new geometry.
      if (cfg_hit) begin
         case (csr_wr_index)
            fbpa_pkg::REG_BASE:  base_in  = csr_wr_data;
            fbpa_pkg::REG_SIZE:  size_in  = csr_wr_data[SW-1:0];
            fbpa_pkg::REG_COUNT: count_in = csr_wr_data[CW-1:0];
            default:             base_in  = base_ff;
         endcase
         head_in          = '0;
         used_in          = '0;
         live_in          = '0;
         clr_ptr_in       = '0;
         clear_pending_in = 1'b0;
         state_in         = S_CLEAR;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_addr_in   = rsp_load ? stage_addr_ff : rsp_addr_ff;
      rsp_status_in = rsp_load ? stage_status_ff : rsp_status_ff;
      rsp_free_in   = rsp_load ? free_now : rsp_free_ff;
      rsp_used_in   = rsp_load ? used_ff : rsp_used_ff;
      rsp_live_in   = rsp_load ? live_ff : rsp_live_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         base_ff          <= fbpa_pkg::BASE_RESET;
         size_ff          <= fbpa_pkg::SIZE_RESET;
         count_ff         <= fbpa_pkg::COUNT_RESET;
         head_ff          <= '0;
         used_ff          <= '0;
         live_ff          <= '0;
         clr_ptr_ff       <= '0;
         clear_pending_ff <= 1'b0;
         div_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         base_ff          <= base_in;
         size_ff          <= size_in;
         count_ff         <= count_in;
         head_ff          <= head_in;
         used_ff          <= used_in;
         live_ff          <= live_in;
         clr_ptr_ff       <= clr_ptr_in;
         clear_pending_ff <= clear_pending_in;
         div_cnt_ff       <= div_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      req_size_ff     <= req_size_in;
      free_addr_ff    <= free_addr_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      prod_ff         <= prod_in;
      stage_addr_ff   <= stage_addr_in;
      stage_status_ff <= stage_status_in;
      rsp_addr_ff     <= rsp_addr_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_free_ff     <= rsp_free_in;
      rsp_used_ff     <= rsp_used_in;
      rsp_live_ff     <= rsp_live_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_block_address    = rsp_addr_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_free_blocks      = rsp_free_ff;
   assign rsp_used_bytes       = rsp_used_ff;
   assign rsp_allocation_count = rsp_live_ff;

   `FBPA_ASSERT_HOLDS(a_live_in_range, clock, reset,
      live_ff <= cnt_eff, "live count exceeds pool size")
   `FBPA_ASSERT_HOLDS(a_head_in_pool, clock, reset,
      head_ff == END_MARK || 32'(head_ff) < 32'(cnt_eff), "free list head outside pool")
   `FBPA_ASSERT_NEXT(a_div_runs, clock, reset,
      state_ff == S_DIV && div_cnt_ff != '0 && !cfg_hit, state_ff == S_DIV,
      "divider left before its last step")
   `FBPA_ASSERT_NEXT(a_result_loaded, clock, reset,
      rsp_load, rsp_valid_ff, "finished result was not presented")

endmodule
